// File: rtl/mtee_pkg.sv
`default_nettype none
package mtee_pkg;

	// Event commands
	typedef enum logic [2:0] {
		CMD_NOTE_ON  = 3'd0,
		CMD_NOTE_OFF = 3'd1,
		CMD_CTRL     = 3'd2,
		CMD_TEMPO    = 3'd3,
		CMD_END      = 3'd4
	} cmd_t;

	// Message bytes
	localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
	localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
	localparam logic [7:0] STATUS_CTRL     = 8'hB0;
	localparam logic [7:0] STATUS_META     = 8'hFF;
	localparam logic [7:0] META_TEMPO      = 8'h51;
	localparam logic [7:0] META_END        = 8'h2F;
	localparam logic [7:0] TEMPO_LEN       = 8'h03;
	localparam logic [7:0] META_END_LEN    = 8'h00;
	localparam logic [7:0] VLQ_MORE        = 8'h80;

	// Encoded event limits
	localparam int unsigned VlqMax = 5;
	localparam int unsigned MsgMax = 6;
	localparam logic [2:0]  MSG_SHORT = 3'd3;
	localparam logic [2:0]  MSG_LONG  = 3'd6;

	// Event queue between front and back
	localparam int unsigned FifoDepth = 2;
	localparam int unsigned FifoAw    = $clog2(FifoDepth);

	typedef struct packed {
		logic [VlqMax-1:0][6:0] grp;      // 7-bit groups, least significant first
		logic [2:0]             grp_cnt;  // 1 to 5
		logic [MsgMax-1:0][7:0] msg;      // message bytes in send order
		logic [2:0]             msg_cnt;  // 3 or 6
	} evt_t;

	typedef struct packed {
		logic valid;
		evt_t evt;
	} push_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

endpackage
`default_nettype wire

// File: rtl/mtee_front.sv
`default_nettype none
module mtee_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [2:0]          cmd,
	input  wire logic [31:0]         tick,
	input  wire logic [7:0]          channel,
	input  wire logic [7:0]          data_one,
	input  wire logic [7:0]          data_two,
	input  wire logic [23:0]         tempo_us,
	input  wire mtee_pkg::fifo_stat_t stat,
	output mtee_pkg::push_t          push
);
	import mtee_pkg::*;

	logic [31:0] prev_q;
	logic [31:0] delta;
	logic        accept;
	logic        known;
	logic [7:0]  ch_nib;
	logic [7:0]  d1;
	logic [7:0]  d2;

	assign in_stall = stat.full;
	assign accept   = in_valid && !in_stall;
	assign delta    = tick - prev_q;
	assign ch_nib   = {4'd0, channel[3:0]};
	assign d1       = {1'b0, data_one[6:0]};
	assign d2       = {1'b0, data_two[6:0]};

	always_comb begin
		push.evt.grp[0] = delta[6:0];
		push.evt.grp[1] = delta[13:7];
		push.evt.grp[2] = delta[20:14];
		push.evt.grp[3] = delta[27:21];
		push.evt.grp[4] = {3'd0, delta[31:28]};
		if (|delta[31:28]) begin
			push.evt.grp_cnt = 3'd5;
		end else if (|delta[27:21]) begin
			push.evt.grp_cnt = 3'd4;
		end else if (|delta[20:14]) begin
			push.evt.grp_cnt = 3'd3;
		end else if (|delta[13:7]) begin
			push.evt.grp_cnt = 3'd2;
		end else begin
			push.evt.grp_cnt = 3'd1;
		end

		known            = 1'b1;
		push.evt.msg     = '0;
		push.evt.msg_cnt = MSG_SHORT;
		case (cmd_t'(cmd))
			CMD_NOTE_ON: begin
				push.evt.msg[0] = STATUS_NOTE_ON | ch_nib;
				push.evt.msg[1] = d1;
				push.evt.msg[2] = d2;
			end
			CMD_NOTE_OFF: begin
				push.evt.msg[0] = STATUS_NOTE_OFF | ch_nib;
				push.evt.msg[1] = d1;
				push.evt.msg[2] = 8'd0;
			end
			CMD_CTRL: begin
				push.evt.msg[0] = STATUS_CTRL | ch_nib;
				push.evt.msg[1] = d1;
				push.evt.msg[2] = d2;
			end
			CMD_TEMPO: begin
				push.evt.msg[0]  = STATUS_META;
				push.evt.msg[1]  = META_TEMPO;
				push.evt.msg[2]  = TEMPO_LEN;
				push.evt.msg[3]  = tempo_us[23:16];
				push.evt.msg[4]  = tempo_us[15:8];
				push.evt.msg[5]  = tempo_us[7:0];
				push.evt.msg_cnt = MSG_LONG;
			end
			CMD_END: begin
				push.evt.msg[0] = STATUS_META;
				push.evt.msg[1] = META_END;
				push.evt.msg[2] = META_END_LEN;
			end
			default: begin
				// drop unknown commands
				known = 1'b0;
			end
		endcase
		push.valid = accept && known;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (push.valid) begin
			prev_q <= (cmd_t'(cmd) == CMD_END) ? 32'd0 : tick;
		end
	end

	a_end_clears_prev: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd_t'(cmd) == CMD_END) |=> (prev_q == 32'd0))
		else $error("previous tick not cleared after end of track");

endmodule
`default_nettype wire

// File: rtl/mtee_fifo.sv
`default_nettype none
module mtee_fifo (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire mtee_pkg::push_t      push,
	input  wire logic                 pop,
	output mtee_pkg::evt_t            head,
	output mtee_pkg::fifo_stat_t      stat
);
	import mtee_pkg::*;

	evt_t              mem_q [FifoDepth];
	logic [FifoAw-1:0] wr_ptr_q;
	logic [FifoAw-1:0] rd_ptr_q;
	logic [FifoAw:0]   cnt_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == (FifoAw+1)'(FifoDepth));

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.evt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push.valid && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push.valid) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.full |-> !push.valid)
		else $error("event queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.empty |-> !pop)
		else $error("event queue read while empty");

endmodule
`default_nettype wire

// File: rtl/mtee_back.sv
`default_nettype none
module mtee_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire mtee_pkg::evt_t       head,
	input  wire mtee_pkg::fifo_stat_t stat,
	output logic                      pop,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [7:0]                out_byte,
	output logic                      last
);
	import mtee_pkg::*;

	logic [3:0] pos_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       load;
	logic [3:0] total;
	logic       is_last;
	logic       in_vlq;
	logic [2:0] gi;
	logic [2:0] mi;
	logic [7:0] nxt_byte;

	assign total   = {1'b0, head.grp_cnt} + {1'b0, head.msg_cnt};
	assign is_last = (pos_q == total - 4'd1);
	assign in_vlq  = (pos_q < {1'b0, head.grp_cnt});
	assign gi      = head.grp_cnt - 3'd1 - pos_q[2:0];
	assign mi      = pos_q[2:0] - head.grp_cnt;
	assign load    = !stat.empty && (!out_valid_q || !out_stall);
	assign pop     = load && is_last;

	always_comb begin
		if (in_vlq) begin
			// set the continuation bit on every delta byte but the last
			nxt_byte = {1'b0, head.grp[gi]};
			if (pos_q != {1'b0, head.grp_cnt} - 4'd1) begin
				nxt_byte = nxt_byte | VLQ_MORE;
			end
		end else begin
			nxt_byte = head.msg[mi];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pos_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				pos_q       <= is_last ? 4'd0 : pos_q + 4'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= nxt_byte;
			last_q <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = byte_q;
	assign last      = last_q;

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!stat.empty |-> (pos_q < total))
		else $error("byte position beyond end of event");

endmodule
`default_nettype wire

// File: rtl/midi_track_event_encoder_unit.sv
`default_nettype none
// Channel | Direction | Handshake           | Payload
// input   | in        | in_valid / in_stall | cmd, tick, channel, data_one, data_two, tempo_us
// output  | out       | out_valid/out_stall | out_byte, last
//
// One input transfer a cycle while the two-entry event queue has room.
// Each event gives 4 to 11 output bytes (1-5 delta bytes, 3 or 6 message
// bytes), one per cycle unless out_stall is high; the serialiser sets the sustained rate.
// An event is written into the queue, then loaded into the output byte register.
// Reset clears the previous tick, the queue and the output valid flag.
// A stall on the output holds the byte register; the queue absorbs two
// events before in_stall rises.
module midi_track_event_encoder_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  cmd,
	input  wire logic [31:0] tick,
	input  wire logic [7:0]  channel,
	input  wire logic [7:0]  data_one,
	input  wire logic [7:0]  data_two,
	input  wire logic [23:0] tempo_us,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             last
);
	import mtee_pkg::*;

	push_t      push;
	evt_t       head;
	fifo_stat_t stat;
	logic       pop;

	// Front: take the delta against the previous tick, split it into 7-bit
	// groups and lay out the message bytes; drop unknown commands.
	mtee_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.tick     (tick),
		.channel  (channel),
		.data_one (data_one),
		.data_two (data_two),
		.tempo_us (tempo_us),
		.stat     (stat),
		.push     (push)
	);

	// Queue: hold encoded events between the two sides.
	mtee_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.stat   (stat)
	);

	// Back: walk the head event byte by byte into the output register,
	// advance the queue on the final byte.
	mtee_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule
`default_nettype wire

// File: test/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Drive note, control, tempo and end-of-track events through the input
	// channel, and rebuild the expected byte stream of each event in a local
	// encoder model: the tick delta as a big-endian 7-bit group quantity, then
	// the message bytes.
	// Each byte that leaves the block is compared with the oldest pending byte.
	// Both ends idle in random bursts, and the receiver holds off once for a
	// long stretch so the event queue fills.

	import mtee_pkg::*;

	// One encoded byte as it should leave the block.
	typedef struct packed {
		logic [7:0] value;
		logic       fin;
	} track_byte_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  cmd;
	logic [31:0] tick;
	logic [7:0]  channel;
	logic [7:0]  data_one;
	logic [7:0]  data_two;
	logic [23:0] tempo_us;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_byte;
	logic        last;

	// Encoder model state and the bytes still owed by the block.
	logic [31:0] track_tick;
	track_byte_t pending_bytes[$];

	int mismatch_count;
	int events_sent;
	int hold_request;
	bit idle_on = 1'b1;

	midi_track_event_encoder_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.tick     (tick),
		.channel  (channel),
		.data_one (data_one),
		.data_two (data_two),
		.tempo_us (tempo_us),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte (out_byte),
		.last     (last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Encode one event: delta groups, most significant first, with the
	// continuation bit on all but the last, then the message. Unknown
	// commands give nothing and leave the track tick alone.
	function automatic void encode_event(logic [2:0] c, logic [31:0] t, logic [7:0] ch,
		logic [7:0] d1, logic [7:0] d2, logic [23:0] tu);
		logic [31:0] delta;
		logic [7:0]  seq [VlqMax + MsgMax];
		int          n;
		int          groups;
		if (c > CMD_END)
			return;
		delta = t - track_tick;
		groups = 1;
		while (groups < VlqMax && (delta >> (7 * groups)) != 0)
			groups++;
		n = 0;
		for (int g = groups - 1; g >= 0; g--) begin
			seq[n] = {1'b0, 7'(delta >> (7 * g))} | ((g != 0) ? VLQ_MORE : 8'h00);
			n++;
		end
		case (cmd_t'(c))
			CMD_NOTE_ON: begin
				seq[n]     = STATUS_NOTE_ON | {4'h0, ch[3:0]};
				seq[n + 1] = {1'b0, d1[6:0]};
				seq[n + 2] = {1'b0, d2[6:0]};
				n += 3;
			end
			CMD_NOTE_OFF: begin
				// velocity is forced to zero
				seq[n]     = STATUS_NOTE_OFF | {4'h0, ch[3:0]};
				seq[n + 1] = {1'b0, d1[6:0]};
				seq[n + 2] = 8'h00;
				n += 3;
			end
			CMD_CTRL: begin
				seq[n]     = STATUS_CTRL | {4'h0, ch[3:0]};
				seq[n + 1] = {1'b0, d1[6:0]};
				seq[n + 2] = {1'b0, d2[6:0]};
				n += 3;
			end
			CMD_TEMPO: begin
				seq[n]     = STATUS_META;
				seq[n + 1] = META_TEMPO;
				seq[n + 2] = TEMPO_LEN;
				seq[n + 3] = tu[23:16];
				seq[n + 4] = tu[15:8];
				seq[n + 5] = tu[7:0];
				n += 6;
			end
			default: begin
				seq[n]     = STATUS_META;
				seq[n + 1] = META_END;
				seq[n + 2] = META_END_LEN;
				n += 3;
			end
		endcase
		// end of track restarts the next track from tick zero
		track_tick = (c == CMD_END) ? 32'd0 : t;
		for (int i = 0; i < n; i++)
			pending_bytes.insert(pending_bytes.size(), '{value: seq[i], fin: (i == n - 1)});
	endfunction

	// Offer one event, after an optional random gap, and hold it until the
	// transfer. Valid stays high on return so back-to-back events need no
	// drop in between.
	task automatic send_event(logic [2:0] c, logic [31:0] t, logic [7:0] ch,
		logic [7:0] d1, logic [7:0] d2, logic [23:0] tu);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		tick     <= t;
		channel  <= ch;
		data_one <= d1;
		data_two <= d2;
		tempo_us <= tu;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		encode_event(c, t, ch, d1, d2, tu);
		events_sent++;
	endtask

	// Tick advance, weighted towards short deltas but reaching every length
	// of the delta encoding.
	function automatic logic [31:0] tick_step();
		case ($urandom_range(0, 9))
			0:       return 32'd0;
			1, 2, 3, 4: return $urandom_range(0, 127);
			5, 6:    return $urandom_range(128, 16383);
			7:       return $urandom_range(16384, 2097151);
			8:       return $urandom_range(2097152, 268435455);
			default: return $urandom;
		endcase
	endfunction

	// One well-formed track: ticks stepped forward (modulo 2^32) from the current track tick,
	// closed by end of track.
	task automatic play_track(int n_events);
		logic [31:0] t;
		t = track_tick;
		repeat (n_events - 1) begin
			t += tick_step();
			send_event(3'($urandom_range(int'(CMD_NOTE_ON), int'(CMD_TEMPO))), t,
				8'($urandom), 8'($urandom), 8'($urandom), 24'($urandom));
		end
		send_event(CMD_END, t + tick_step(), 8'($urandom), 8'($urandom), 8'($urandom),
			24'($urandom));
	endtask

	// Every command, field extremes and each delta length boundary; then a
	// backwards tick, unknown commands and the track restart.
	task automatic test_directed();
		logic [31:0] t;
		t = 32'd0;
		send_event(CMD_NOTE_ON, t, 8'h00, 8'h00, 8'h00, 24'h000000);
		t += 32'd127;
		send_event(CMD_NOTE_ON, t, 8'hFF, 8'hFF, 8'hFF, 24'hFFFFFF);
		t += 32'd128;
		send_event(CMD_NOTE_OFF, t, 8'h5A, 8'hA5, 8'hFF, 24'h5A5A5A);
		t += 32'd16383;
		send_event(CMD_CTRL, t, 8'hF0, 8'h7F, 8'h80, 24'h000000);
		t += 32'd16384;
		send_event(CMD_CTRL, t, 8'h0F, 8'h80, 8'h7F, 24'hFFFFFF);
		t += 32'd2097151;
		send_event(CMD_TEMPO, t, 8'hFF, 8'hFF, 8'hFF, 24'h000000);
		t += 32'd2097152;
		send_event(CMD_TEMPO, t, 8'h00, 8'h00, 8'h00, 24'hFFFFFF);
		t += 32'd268435455;
		send_event(CMD_NOTE_ON, t, 8'h3C, 8'h3C, 8'h64, 24'h123456);
		t += 32'd268435456;
		send_event(CMD_NOTE_OFF, t, 8'hC3, 8'hC3, 8'h00, 24'hEDCBA9);
		// tick one step back: the delta wraps to the full 5-byte quantity,
		// and with a tempo message this is the longest event
		send_event(CMD_TEMPO, t - 32'd1, 8'h00, 8'h00, 8'h00, 24'hA5A5A5);
		send_event(3'd5, 32'hFFFFFFFF, 8'hFF, 8'hFF, 8'hFF, 24'hFFFFFF);
		send_event(3'd6, 32'h00000000, 8'h00, 8'h00, 8'h00, 24'h000000);
		send_event(3'b111, 32'h89ABCDEF, 8'h5A, 8'hA5, 8'h5A, 24'hA5A5A5);
		send_event(CMD_END, 32'hFFFFFFFF, 8'hFF, 8'hFF, 8'hFF, 24'hFFFFFF);
		// a fresh track starts from tick zero
		send_event(CMD_NOTE_ON, 32'd0, 8'h09, 8'h24, 8'h7F, 24'h000000);
		send_event(CMD_END, 32'd0, 8'h00, 8'h00, 8'h00, 24'h000000);
		send_event(CMD_NOTE_ON, 32'hFFFFFFFF, 8'h01, 8'h40, 8'h40, 24'h000000);
		send_event(CMD_END, 32'h12345678, 8'h00, 8'h00, 8'h00, 24'h000000);
	endtask

	// Hold the output off for a long stretch while events keep coming, so
	// the event queue fills and the input stalls.
	task automatic test_output_hold();
		idle_on = 1'b0;
		hold_request = 300;
		play_track(20);
		idle_on = 1'b1;
	endtask

	// Mostly well-formed tracks with random content; the rest is noise:
	// unknown commands and events at arbitrary ticks.
	task automatic test_random_tracks();
		while (events_sent < 235) begin
			if ($urandom_range(0, 6) == 0) begin
				if ($urandom_range(0, 1) == 0)
					send_event(3'($urandom_range(int'(CMD_END) + 1, 7)), $urandom,
						8'($urandom), 8'($urandom), 8'($urandom), 24'($urandom));
				else
					send_event(3'($urandom_range(int'(CMD_NOTE_ON), int'(CMD_END))), $urandom,
						8'($urandom), 8'($urandom), 8'($urandom), 24'($urandom));
			end else begin
				play_track($urandom_range(1, 12));
			end
		end
	endtask

	// Closing stretch with no idling on either side.
	task automatic test_full_rate();
		idle_on = 1'b0;
		while (events_sent < 265)
			play_track($urandom_range(2, 8));
	endtask

	// Output side: check each transfer, then choose next cycle's stall from
	// a pending long hold, a running burst, or a fresh random burst.
	initial begin
		int stall_left;
		int hold_left;
		track_byte_t want;
		stall_left = 0;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pending_bytes.size() == 0) begin
					$display("%0t: unexpected byte %02h (last %0b), nothing pending",
						$time, out_byte, last);
					mismatch_count++;
				end else begin
					want = pending_bytes.pop_front();
					if (out_byte !== want.value) begin
						$display("%0t: out_byte mismatch, expected %02h, got %02h",
							$time, want.value, out_byte);
						mismatch_count++;
					end
					if (last !== want.fin) begin
						$display("%0t: last mismatch, expected %0b, got %0b",
							$time, want.fin, last);
						mismatch_count++;
					end
				end
			end
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 9) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Sequence the tests, then drain and report.
	initial begin
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		cmd      <= CMD_NOTE_ON;
		tick     <= '0;
		channel  <= '0;
		data_one <= '0;
		data_two <= '0;
		tempo_us <= '0;
		track_tick = 32'd0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_output_hold();
		test_random_tracks();
		test_full_rate();

		in_valid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
		// allow for any stray bytes behind the last expected one
		repeat (16) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: midi_track_event_encoder_unit.f
rtl/mtee_pkg.sv
rtl/mtee_front.sv
rtl/mtee_fifo.sv
rtl/mtee_back.sv
rtl/midi_track_event_encoder_unit.sv
test/tb.sv
